// ----- hdl/wpfm_pkg.sv -----
// Shared constants and controller/datapath interface types for the flow meter.
`timescale 1ns / 1ps

package wpfm_pkg;

    // Counter width default (pulse and millisecond counters)
    localparam int COUNT_BITS_DEF = 32;

    // Configuration register widths, indexes and reset values
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K_X100 = 8'd1;
    localparam logic [CFG_DATA_W-1:0] WINDOW_MS_RST = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] K_X100_RST = 16'd750;

    // Flow result format
    localparam int FLOW_W = 24;
    localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

    // Scale factor 10^8 turns pulses / (ms * Hz-per-lpm/100) into milli-lpm
    localparam int SCALE_W = 27;
    localparam logic [SCALE_W-1:0] SCALE_NUM = 27'd100000000;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;   // process one input beat
        logic mul;      // form numerator and divisor products
        logic check;    // test for zero divisor or clipping, seed the divider
        logic step;     // one quotient bit
        logic last;     // final quotient bit, deliver the result
    } wpfm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic compute_due;  // accepted beat starts a new computation
        logic sat_hit;      // result clips, no division needed
    } wpfm_sts_t;

endpackage

// ----- hdl/wpfm_ctrl.sv -----
// Controller state machine sequencing the multiply, check and division steps.
`timescale 1ns / 1ps

module wpfm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  wpfm_pkg::wpfm_sts_t  sts,
    output wpfm_pkg::wpfm_cmd_t  cmd,
    output logic                 busy
);

    localparam int STEP_W = $clog2(wpfm_pkg::FLOW_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(wpfm_pkg::FLOW_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && sts.compute_due)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    step_cnt_reg <= STEP_LAST;
                    state_reg    <= sts.sat_hit ? ST_IDLE : ST_DIV;
                end
                ST_DIV:
                begin
                    step_cnt_reg <= step_cnt_reg - 1'b1;
                    if (step_cnt_reg == '0)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.accept = (state_reg == ST_IDLE) && accept;
        cmd.mul    = (state_reg == ST_MUL);
        cmd.check  = (state_reg == ST_CHECK);
        cmd.step   = (state_reg == ST_DIV);
        cmd.last   = (state_reg == ST_DIV) && (step_cnt_reg == '0);
        busy       = (state_reg != ST_IDLE);
    end

endmodule

// ----- hdl/wpfm_datapath.sv -----
// Datapath: counters, configuration, products, restoring divider, output register.
`timescale 1ns / 1ps

module wpfm_datapath #(
    parameter int COUNT_BITS = wpfm_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wpfm_pkg::wpfm_cmd_t               cmd,
    output wpfm_pkg::wpfm_sts_t               sts,
    input  logic                              cfg_we,
    input  logic [wpfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wpfm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              sensor_level,
    input  logic                              ms_tick,
    input  logic                              query,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [wpfm_pkg::FLOW_W-1:0]       flow_milli_lpm,
    output logic                              fresh,
    output logic                              saturated
);

    localparam int FW    = wpfm_pkg::FLOW_W;
    localparam int NUM_W = COUNT_BITS + wpfm_pkg::SCALE_W;
    localparam int DEN_W = COUNT_BITS + wpfm_pkg::CFG_DATA_W;
    localparam int CMP_W = DEN_W + FW;

    logic [wpfm_pkg::CFG_DATA_W-1:0] window_reg;
    logic [wpfm_pkg::CFG_DATA_W-1:0] k_reg;
    logic [COUNT_BITS-1:0]           pulse_reg, pulse_next;
    logic [COUNT_BITS-1:0]           elapsed_reg, elapsed_next;
    logic                            prev_level_reg;
    logic [FW-1:0]                   held_reg;
    logic [COUNT_BITS-1:0]           pulse_snap_reg;
    logic [COUNT_BITS-1:0]           elapsed_snap_reg;
    logic [NUM_W-1:0]                num_reg;
    logic [DEN_W-1:0]                den_reg;
    logic [DEN_W:0]                  rem_reg;
    logic [FW-1:0]                   quo_reg;
    logic                            out_valid_reg;
    logic [FW-1:0]                   flow_reg;
    logic                            fresh_reg;
    logic                            sat_reg;

    logic [COUNT_BITS-1:0] elapsed_tick;
    logic                  edge_seen;
    logic [DEN_W:0]        rem_shift;
    logic                  rem_ge;
    logic [DEN_W:0]        rem_next;
    logic [FW-1:0]         quo_next;

    // Tick first, then query decision, then the pin edge
    always_comb
    begin
        elapsed_tick = elapsed_reg;
        if (ms_tick && (elapsed_reg != '1))
        begin
            elapsed_tick = elapsed_reg + 1'b1;
        end
        edge_seen = sensor_level && !prev_level_reg;
        sts.compute_due = query && (elapsed_tick >= COUNT_BITS'(window_reg));
        sts.sat_hit = (den_reg == '0) ||
                      ({{(CMP_W - NUM_W){1'b0}}, num_reg} >= {den_reg, {FW{1'b0}}});

        if (sts.compute_due)
        begin
            elapsed_next = '0;
            pulse_next   = edge_seen ? COUNT_BITS'(1) : '0;
        end
        else
        begin
            elapsed_next = elapsed_tick;
            pulse_next   = pulse_reg;
            if (edge_seen && (pulse_reg != '1))
            begin
                pulse_next = pulse_reg + 1'b1;
            end
        end

        rem_shift = {rem_reg[DEN_W-1:0], quo_reg[FW-1]};
        rem_ge    = (rem_shift >= {1'b0, den_reg});
        rem_next  = rem_ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
        quo_next  = {quo_reg[FW-2:0], rem_ge};
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= wpfm_pkg::WINDOW_MS_RST;
            k_reg          <= wpfm_pkg::K_X100_RST;
            pulse_reg      <= '0;
            elapsed_reg    <= '0;
            prev_level_reg <= 1'b0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == wpfm_pkg::REG_WINDOW_MS))
            begin
                window_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == wpfm_pkg::REG_K_X100))
            begin
                k_reg <= cfg_data;
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.accept)
            begin
                pulse_reg      <= pulse_next;
                elapsed_reg    <= elapsed_next;
                prev_level_reg <= sensor_level;
                if (query && !sts.compute_due)
                begin
                    out_valid_reg <= 1'b1;
                end
            end

            if (cmd.check && sts.sat_hit)
            begin
                held_reg      <= wpfm_pkg::FLOW_MAX;
                out_valid_reg <= 1'b1;
            end

            if (cmd.last)
            begin
                held_reg      <= quo_next;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Operand, divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept && sts.compute_due)
        begin
            pulse_snap_reg   <= pulse_reg;
            elapsed_snap_reg <= elapsed_tick;
        end
        if (cmd.accept && query && !sts.compute_due)
        begin
            flow_reg  <= held_reg;
            fresh_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end
        if (cmd.mul)
        begin
            num_reg <= NUM_W'(pulse_snap_reg) * NUM_W'(wpfm_pkg::SCALE_NUM);
            den_reg <= DEN_W'(elapsed_snap_reg) * DEN_W'(k_reg);
        end
        if (cmd.check)
        begin
            // Quotient fits in FW bits here, so the top part is below the divisor
            rem_reg <= (DEN_W + 1)'(num_reg[NUM_W-1:FW]);
            quo_reg <= num_reg[FW-1:0];
            if (sts.sat_hit)
            begin
                flow_reg  <= wpfm_pkg::FLOW_MAX;
                fresh_reg <= 1'b1;
                sat_reg   <= 1'b1;
            end
        end
        if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.last)
        begin
            flow_reg  <= quo_next;
            fresh_reg <= 1'b1;
            sat_reg   <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign flow_milli_lpm = flow_reg;
    assign fresh          = fresh_reg;
    assign saturated      = sat_reg;

endmodule

// ----- hdl/windowed_pulse_flow_meter_unit.sv -----
// Top level of the windowed pulse flow meter: handshakes, controller and datapath.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  ----------------------------------------
//  in        sink       in_valid / in_stall  sensor_level, ms_tick, query
//  out       source     out_valid / out_stall flow_milli_lpm, fresh, saturated
//  cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
//  A beat without a due computation is taken without waiting for a computation;
//  a held-value query loads the output register as it is accepted. A query that
//  closes a window holds the input through the multiply and check states when
//  the result clips (or the divisor is zero), and through those and 24 steps of
//  the radix-2 restoring divider otherwise, one quotient bit per cycle.
//  A query beat also waits while an earlier result sits stalled in the output
//  register; beats without a query keep flowing then.
//  Reset (rst_n low, asynchronous) clears counters, held flow and the pin
//  history and loads window_ms = 1000, k_x100 = 750. cfg_ready is always high.
//
module windowed_pulse_flow_meter_unit #(
    parameter int COUNT_BITS = wpfm_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             sensor_level,
    input  logic                             ms_tick,
    input  logic                             query,
    // result beats
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [wpfm_pkg::FLOW_W-1:0]      flow_milli_lpm,
    output logic                             fresh,
    output logic                             saturated,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wpfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wpfm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    wpfm_pkg::wpfm_cmd_t cmd;
    wpfm_pkg::wpfm_sts_t sts;
    logic                busy;
    logic                accept;

    // Hold all input while a computation runs; hold a query beat only while
    // the output register is occupied and stalled, since it needs that slot.
    assign in_stall  = busy || (out_valid && out_stall && query);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    wpfm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    wpfm_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sensor_level   (sensor_level),
        .ms_tick        (ms_tick),
        .query          (query),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .flow_milli_lpm (flow_milli_lpm),
        .fresh          (fresh),
        .saturated      (saturated)
    );

endmodule

// ----- hdl/wpfm_checker.sv -----
// Port-level checker for the flow meter, bound to the top level.
`timescale 1ns / 1ps

module wpfm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        query,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [wpfm_pkg::FLOW_W-1:0] flow_milli_lpm,
    input logic                        fresh,
    input logic                        saturated
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // Clipping is only reported on freshly computed results
    a_sat_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> fresh)
        else $error("saturated set on a held result");

    // A clipped result carries the full-scale value
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> flow_milli_lpm == wpfm_pkg::FLOW_MAX)
        else $error("saturated result is not full scale");

    // An accepted beat without a query never raises a new result
    a_no_query: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !query |=> !$rose(out_valid))
        else $error("result appeared without a query");

endmodule

bind windowed_pulse_flow_meter_unit wpfm_checker u_wpfm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .query          (query),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .flow_milli_lpm (flow_milli_lpm),
    .fresh          (fresh),
    .saturated      (saturated)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for the windowed pulse flow meter unit.
`timescale 1ns / 1ps

module testbench;

    // Counter width of the instance under test (default parameter).
    localparam int CNT_W = wpfm_pkg::COUNT_BITS_DEF;
    // Register index past the two real registers; writes to it are dropped.
    localparam logic [wpfm_pkg::CFG_IDX_W-1:0] REG_SPARE = '1;
    // Settle time after each drain, in clock cycles.
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT = 200000;
    localparam int REPORT_LIMIT = 10;

    // One pin sample with its tick and query flags.
    typedef struct packed {
        logic level;
        logic tick;
        logic query;
    } pin_sample_t;

    // One flow reading as it leaves the block.
    typedef struct packed {
        logic [wpfm_pkg::FLOW_W-1:0] flow;
        logic                        fresh;
        logic                        sat;
    } flow_reading_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_BURSTY
    } rx_mode_t;

    // ------------------------------------------------------------------
    // Clock, reset and block connections. Every input starts known.
    // ------------------------------------------------------------------
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            sensor_level = 1'b0;
    logic                            ms_tick = 1'b0;
    logic                            query = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [wpfm_pkg::FLOW_W-1:0]     flow_milli_lpm;
    logic                            fresh;
    logic                            saturated;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [wpfm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wpfm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    windowed_pulse_flow_meter_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sensor_level   (sensor_level),
        .ms_tick        (ms_tick),
        .query          (query),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .flow_milli_lpm (flow_milli_lpm),
        .fresh          (fresh),
        .saturated      (saturated),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------
    // Flow meter predictor: its own copy of counters, held flow, pin
    // history and both registers, starting from the reset state.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]                meter_pulses = '0;
    logic [CNT_W-1:0]                meter_ms = '0;
    logic [wpfm_pkg::FLOW_W-1:0]     meter_held = '0;
    logic                            meter_prev = 1'b0;
    logic [wpfm_pkg::CFG_DATA_W-1:0] meter_window = wpfm_pkg::WINDOW_MS_RST;
    logic [wpfm_pkg::CFG_DATA_W-1:0] meter_kx100 = wpfm_pkg::K_X100_RST;

    flow_reading_t         flow_expected[$];
    pin_sample_t           pending_beats[$];
    pin_sample_t           held_beat = '0;

    int beats_queued = 0;
    int beats_done = 0;
    int readings_checked = 0;
    int fresh_seen = 0;
    int clipped_seen = 0;
    int held_seen = 0;
    int settings_run = 0;
    int mismatches = 0;

    // Advance the meter by one accepted beat: tick first, then the query,
    // then the pin edge, so an edge on the query beat opens the new window.
    function automatic void advance_meter(input pin_sample_t s);
        logic [63:0]   numer;
        logic [63:0]   denom;
        logic [63:0]   quot;
        flow_reading_t r;
        if (s.tick && meter_ms != {CNT_W{1'b1}})
            meter_ms = meter_ms + 1'b1;
        if (s.query)
        begin
            if (meter_ms < meter_window)
            begin
                // Window still open: return the held value, never flagged.
                r.flow  = meter_held;
                r.fresh = 1'b0;
                r.sat   = 1'b0;
            end
            else
            begin
                numer = 64'(meter_pulses) * 64'(wpfm_pkg::SCALE_NUM);
                denom = 64'(meter_ms) * 64'(meter_kx100);
                r.fresh = 1'b1;
                if (denom == 64'd0)
                begin
                    // Zero divisor: zero factor, or zero window with no time.
                    r.flow = wpfm_pkg::FLOW_MAX;
                    r.sat  = 1'b1;
                end
                else
                begin
                    quot = numer / denom;
                    if (quot > 64'(wpfm_pkg::FLOW_MAX))
                    begin
                        r.flow = wpfm_pkg::FLOW_MAX;
                        r.sat  = 1'b1;
                    end
                    else
                    begin
                        r.flow = quot[wpfm_pkg::FLOW_W-1:0];
                        r.sat  = 1'b0;
                    end
                end
                meter_pulses = '0;
                meter_ms     = '0;
                meter_held   = r.flow;
            end
            flow_expected.push_back(r);
        end
        if (s.level && !meter_prev && meter_pulses != {CNT_W{1'b1}})
            meter_pulses = meter_pulses + 1'b1;
        meter_prev = s.level;
    endfunction

    // Count a failure; report only the first few in full.
    task automatic log_bad(input string msg);
        if (mismatches < REPORT_LIMIT)
            $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: drain the pending queue in bursts of random length
    // with random gaps. Hold a stalled beat unchanged; feed the predictor
    // at the edge where a beat is taken.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    logic        beat_taken;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            sensor_level <= 1'b0;
            ms_tick      <= 1'b0;
            query        <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            beat_taken = in_valid && (in_stall === 1'b0);
            if (beat_taken)
            begin
                advance_meter(held_beat);
                beats_done++;
            end
            if (in_valid && !beat_taken)
            begin
                // Stalled: keep valid and payload as they are.
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                held_beat = pending_beats.pop_front();
                sensor_level <= held_beat.level;
                ms_tick      <= held_beat.tick;
                query        <= held_beat.query;
                in_valid     <= 1'b1;
                // Long unbroken runs now and then, short choppy ones otherwise.
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 20);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall in segments of random length, each with its own
    // pattern: none, light random, heavy random, or a square wave.
    // ------------------------------------------------------------------
    rx_mode_t    rx_mode = RX_FREE;
    int unsigned rx_span = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_mode = RX_FREE;
            rx_span = 0;
        end
        else
        begin
            if (rx_span == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_span = $urandom_range(8, 64);
            end
            else
            begin
                rx_span--;
            end
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:  out_stall <= rx_span[3];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken beat with the oldest expectation.
    // ------------------------------------------------------------------
    flow_reading_t want;
    flow_reading_t got;

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            got = '{flow: flow_milli_lpm, fresh: fresh, sat: saturated};
            if (flow_expected.size() == 0)
            begin
                log_bad($sformatf("unexpected reading flow=%0d fresh=%0b saturated=%0b",
                                  got.flow, got.fresh, got.sat));
            end
            else
            begin
                want = flow_expected.pop_front();
                if (got.flow !== want.flow || got.fresh !== want.fresh
                    || got.sat !== want.sat)
                    log_bad($sformatf({"reading %0d: flow exp %0d got %0d, fresh exp %0b ",
                                       "got %0b, saturated exp %0b got %0b"},
                                      readings_checked, want.flow, got.flow,
                                      want.fresh, got.fresh, want.sat, got.sat));
                readings_checked++;
                if (!want.fresh)
                    held_seen++;
                else if (want.sat)
                    clipped_seen++;
                else
                    fresh_seen++;
            end
        end
    end

    // Track register writes in the predictor; ignore unknown indexes.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready === 1'b1)
        begin
            case (cfg_index)
                wpfm_pkg::REG_WINDOW_MS: meter_window = cfg_data;
                wpfm_pkg::REG_K_X100:    meter_kx100  = cfg_data;
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic level, input logic tick, input logic ask);
        pin_sample_t s;
        s.level = level;
        s.tick  = tick;
        s.query = ask;
        pending_beats.push_back(s);
        beats_queued++;
    endtask

    // Write one register; drop valid at the handshake edge.
    task automatic write_reg(input logic [wpfm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wpfm_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every queued beat to be taken and every reading to arrive,
    // then wait out the settle time. Readings still missing count as failures.
    task automatic wait_quiet();
        int waited;
        waited = 0;
        while ((beats_done != beats_queued || flow_expected.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (flow_expected.size() != 0)
        begin
            log_bad($sformatf("%0d readings never arrived", flow_expected.size()));
            flow_expected.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Queue measurement windows: random pin activity and ticks until the
    // window should have closed, then a query. Mix in early queries and
    // stray queries inside a window so held readings show up as well.
    task automatic queue_windows(input int n_items, input int tick_pct, input int win);
        int          made;
        int          ticks;
        int          goal;
        pin_sample_t s;
        made = 0;
        while (made < n_items)
        begin
            ticks = 0;
            goal  = win + $urandom_range(0, 2);
            if ($urandom_range(0, 5) == 0)
                goal = $urandom_range(0, win);
            while (ticks < goal && made < n_items)
            begin
                s.level = 1'($urandom_range(0, 1));
                s.tick  = ($urandom_range(0, 99) < tick_pct);
                s.query = ($urandom_range(0, 60) == 0);
                queue_beat(s.level, s.tick, s.query);
                ticks += int'(s.tick);
                made++;
            end
            queue_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
            made++;
        end
    endtask

    // Settle, load a new setting, then run random windows under it.
    task automatic run_setting(input logic [wpfm_pkg::CFG_DATA_W-1:0] win,
                               input logic [wpfm_pkg::CFG_DATA_W-1:0] kx100,
                               input int tick_pct, input int n_items);
        wait_quiet();
        write_reg(wpfm_pkg::REG_K_X100, kx100);
        write_reg(wpfm_pkg::REG_WINDOW_MS, win);
        settings_run++;
        queue_windows(n_items, tick_pct, int'(win));
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, directed beats, then random settings.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: queries inside the 1000 ms window return the held zero.
        queue_beat(1'b0, 1'b0, 1'b1);
        queue_beat(1'b1, 1'b1, 1'b0);
        queue_beat(1'b0, 1'b0, 1'b1);
        wait_quiet();

        // Zero window and zero factor: the query computes with a zero divisor.
        write_reg(wpfm_pkg::REG_WINDOW_MS, '0);
        write_reg(wpfm_pkg::REG_K_X100, '0);
        queue_beat(1'b1, 1'b0, 1'b1);
        wait_quiet();

        // Factor of one: zero window with no time elapsed, then a clipped rate.
        write_reg(wpfm_pkg::REG_K_X100, 16'd1);
        queue_beat(1'b0, 1'b0, 1'b1);
        queue_beat(1'b1, 1'b1, 1'b0);
        queue_beat(1'b0, 1'b1, 1'b1);
        wait_quiet();

        // Largest factor, short window; writes past the last register are dropped.
        write_reg(wpfm_pkg::REG_WINDOW_MS, 16'd4);
        write_reg(wpfm_pkg::REG_K_X100, '1);
        write_reg(REG_SPARE, '1);
        write_reg(REG_SPARE, '0);
        queue_beat(1'b1, 1'b1, 1'b0);
        queue_beat(1'b0, 1'b1, 1'b0);
        queue_beat(1'b1, 1'b1, 1'b0);
        queue_beat(1'b0, 1'b0, 1'b1);   // one tick short: held clipped value
        queue_beat(1'b1, 1'b1, 1'b1);   // tick closes the window, edge opens the next
        queue_beat(1'b0, 1'b0, 1'b1);
        queue_beat(1'b1, 1'b0, 1'b0);

        // Random settings, the extremes among them.
        run_setting(16'd5, wpfm_pkg::K_X100_RST, 50, 200);
        run_setting(16'd1, 16'd1, 60, 120);
        run_setting(16'd0, 16'hFFFF, 30, 120);
        run_setting(16'hFFFF, 16'd300, 70, 150);
        run_setting(16'($urandom_range(1, 30)), 16'($urandom_range(1, 65535)), 40, 200);
        run_setting(16'd12, 16'd0, 50, 100);
        run_setting(16'd3, 16'($urandom_range(1, 65535)), 90, 200);
        run_setting(16'd20, wpfm_pkg::K_X100_RST, 100, 160);
        run_setting(16'd2, 16'hFFFF, 20, 100);
        wait_quiet();

        $display("Sent %0d input beats under %0d random settings after the directed beats.",
                 beats_done, settings_run);
        $display("Checked %0d readings: %0d computed, %0d clipped, %0d held; %0d failures.",
                 readings_checked, fresh_seen, clipped_seen, held_seen, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
